>>> rtl/core/ple_pkg.sv
// shared types and constants for the positional list engine
package ple_pkg;

   localparam int unsigned FUNC_W = 3;
   localparam int unsigned POS_W  = 7;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned LEN_W  = 7;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } ple_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STAT_W-1:0]        status;
      logic [LEN_W-1:0]         length;
   } ple_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CAP,
      ST_RD,
      ST_WR,
      ST_PUT,
      ST_DONE
   } ple_state_type;

endpackage

>>> rtl/core/ple_req_if.sv
// command channel of the positional list engine
interface ple_req_if;
   logic                 valid;
   logic                 ready;
   ple_pkg::ple_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/ple_rsp_if.sv
// result channel of the positional list engine
interface ple_rsp_if;
   logic                 valid;
   logic                 ready;
   ple_pkg::ple_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/positional_list_engine.sv
// clear, errors and unused codes go straight to DONE; get reads its element (FETCH, CAP);
// insert or push at position p moves each element from p on up one place by a read and a
// write (RD, WR), then writes the value (PUT); delete reads its element (FETCH, CAP), then
// moves each later element down one place (RD, WR). a new item is taken in the cycle after
// the result register is loaded, which waits while the last result is held; items never overlap.
// reset (synchronous) empties the list and drops any pending result; the store is not cleared.
module positional_list_engine #(
   parameter int unsigned DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   ple_req_if.sink    req_chan,
   ple_rsp_if.source  rsp_chan
);

   localparam int unsigned AW   = $clog2(DEPTH);
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

   ple_pkg::ple_state_type state_ff, state_in;

   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    idx_ff, idx_in;
   logic [AW-1:0]                    k_ff, k_in;
   logic [ple_pkg::FUNC_W-1:0]       func_ff, func_in;
   logic [ple_pkg::DATA_W-1:0]       val_ff, val_in;
   logic [ple_pkg::STAT_W-1:0]       status_ff, status_in;
   logic [ple_pkg::DATA_W-1:0]       data_ff, data_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ple_pkg::ple_rsp_type             rsp_ff, rsp_in;

   logic                             req_fire;
   logic                             out_free;
   logic                             shift_up;
   logic [ple_pkg::POS_W-1:0]        acc_k7;
   logic [CMPW-1:0]                  acc_k_ext;
   logic [CMPW-1:0]                  cnt_ext;
   logic [ple_pkg::STAT_W-1:0]       acc_status;
   logic [CW-1:0]                    k_wide;
   logic [CW-1:0]                    idx_step;

   logic                             rd_en;
   logic [AW-1:0]                    rd_addr;
   logic [ple_pkg::DATA_W-1:0]       rd_data;
   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [ple_pkg::DATA_W-1:0]       wr_data;

   ple_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready   = (state_ff == ple_pkg::ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign shift_up = (func_ff == ple_pkg::FUNC_PUSH) || (func_ff == ple_pkg::FUNC_INSERT);
   assign k_wide   = CW'(k_ff);
   // shared index unit: one step down for push and insert, one step up for delete
   assign idx_step = shift_up ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));

   // position decode and range check for the item being accepted
   always_comb begin
      acc_k7 = '0;
      if (req_chan.payload.position != '0) begin
         acc_k7 = req_chan.payload.position - ple_pkg::POS_W'(1);
      end
      if (req_chan.payload.func == ple_pkg::FUNC_PUSH) begin
         acc_k7 = '0;
      end
      acc_k_ext = CMPW'(acc_k7);
      cnt_ext   = CMPW'(count_ff);
      unique case (req_chan.payload.func)
         ple_pkg::FUNC_PUSH, ple_pkg::FUNC_INSERT: begin
            if (count_ff >= CW'(DEPTH)) begin
               acc_status = ple_pkg::STATUS_FULL;
            end else if (acc_k_ext > cnt_ext) begin
               acc_status = ple_pkg::STATUS_RANGE;
            end else begin
               acc_status = ple_pkg::STATUS_OK;
            end
         end
         ple_pkg::FUNC_DELETE, ple_pkg::FUNC_GET: begin
            acc_status = (acc_k_ext >= cnt_ext) ? ple_pkg::STATUS_RANGE
                                                : ple_pkg::STATUS_OK;
         end
         default: begin
            acc_status = ple_pkg::STATUS_OK;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (acc_status != ple_pkg::STATUS_OK) begin
                  state_in = ple_pkg::ST_DONE;
               end else begin
                  unique case (req_chan.payload.func)
                     ple_pkg::FUNC_PUSH, ple_pkg::FUNC_INSERT: begin
                        state_in = (cnt_ext > acc_k_ext) ? ple_pkg::ST_RD : ple_pkg::ST_PUT;
                     end
                     ple_pkg::FUNC_DELETE, ple_pkg::FUNC_GET: begin
                        state_in = ple_pkg::ST_FETCH;
                     end
                     default: begin
                        state_in = ple_pkg::ST_DONE;
                     end
                  endcase
               end
            end
         end
         ple_pkg::ST_FETCH: begin
            state_in = ple_pkg::ST_CAP;
         end
         ple_pkg::ST_CAP: begin
            if ((func_ff == ple_pkg::FUNC_DELETE) && ((k_wide + CW'(1)) < count_ff)) begin
               state_in = ple_pkg::ST_RD;
            end else begin
               state_in = ple_pkg::ST_DONE;
            end
         end
         ple_pkg::ST_RD: begin
            state_in = ple_pkg::ST_WR;
         end
         ple_pkg::ST_WR: begin
            if (shift_up) begin
               state_in = (idx_step > k_wide) ? ple_pkg::ST_RD : ple_pkg::ST_PUT;
            end else begin
               state_in = ((idx_ff + CW'(2)) < count_ff) ? ple_pkg::ST_RD : ple_pkg::ST_DONE;
            end
         end
         ple_pkg::ST_PUT: begin
            state_in = ple_pkg::ST_DONE;
         end
         ple_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ple_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ple_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and store control
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      func_in      = func_ff;
      val_in       = val_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rd_en        = 1'b0;
      rd_addr      = k_ff;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = val_ff;
      unique case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (req_fire) begin
               func_in   = req_chan.payload.func;
               val_in    = req_chan.payload.value;
               status_in = acc_status;
               data_in   = '0;
               k_in      = acc_k_ext[AW-1:0];
               idx_in    = count_ff;
            end
         end
         ple_pkg::ST_FETCH: begin
            rd_en   = 1'b1;
            rd_addr = k_ff;
         end
         ple_pkg::ST_CAP: begin
            data_in = rd_data;
            idx_in  = k_wide;
         end
         ple_pkg::ST_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_step[AW-1:0];
         end
         ple_pkg::ST_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            idx_in  = idx_step;
         end
         ple_pkg::ST_PUT: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            wr_data = val_ff;
         end
         ple_pkg::ST_DONE: begin
            if (out_free) begin
               unique case (func_ff)
                  ple_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  ple_pkg::FUNC_PUSH, ple_pkg::FUNC_INSERT: begin
                     if (status_ff == ple_pkg::STATUS_OK) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ple_pkg::FUNC_DELETE: begin
                     if (status_ff == ple_pkg::STATUS_OK) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
               rsp_in.data   = data_ff;
               rsp_in.status = status_ff;
               rsp_in.length = ple_pkg::LEN_W'(count_in);
               rsp_valid_in  = 1'b1;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      k_ff      <= k_in;
      func_ff   <= func_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      rsp_ff    <= rsp_in;
   end

endmodule

>>> rtl/core/ple_store.sv
// element store: one write port, one registered read port
module ple_store #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [ple_pkg::DATA_W-1:0]          wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [ple_pkg::DATA_W-1:0]          rd_data
);

   logic [ple_pkg::DATA_W-1:0] mem [DEPTH];
   logic [ple_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/positional_list_engine_test.sv
// self-checking testbench for the positional list engine
module positional_list_engine_test;
   import ple_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LIST_DEPTH    = 64;
   localparam int unsigned MAX_POS       = 64;
   localparam int unsigned RANDOM_ITEMS  = 1130;
   localparam int unsigned PHASE_ITEMS   = 40;
   localparam int unsigned LONG_HOLD     = 400;
   localparam int unsigned SETTLE_CYCLES = 2 * LIST_DEPTH + 20;
   localparam int unsigned STALL_LIMIT   = 3000;

   // first of the func codes that carry no operation
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;

   typedef enum logic [1:0] {
      MIX_GROW,
      MIX_SHRINK,
      MIX_EVEN
   } mix_kind_type;

   typedef struct {
      ple_req_type cmd;
      int unsigned gap;
      bit          drain;
   } queued_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ple_req_if req_bus ();
   ple_rsp_if rsp_bus ();

   positional_list_engine #(
      .DEPTH(LIST_DEPTH)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always #5 clock = ~clock;

   // mirror of the list contents and the results still owed by the block
   logic signed [DATA_W-1:0] list_mirror[$];
   ple_rsp_type              due_results[$];
   queued_cmd_type           pending_cmds[$];

   int unsigned error_count     = 0;
   int unsigned items_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned full_seen       = 0;
   int unsigned range_seen      = 0;
   int unsigned peak_length     = 0;
   int unsigned long_hold_asked = 0;
   int unsigned long_hold_done  = 0;
   bit          rsp_eager       = 1'b0;

   function automatic void predict_list_op(ple_req_type c);
      ple_rsp_type r;
      int unsigned slot;
      r.data   = '0;
      r.status = STATUS_OK;
      slot     = (c.position == 0) ? 0 : c.position - 1;
      case (c.func)
         FUNC_CLEAR: begin
            list_mirror.delete();
         end
         FUNC_PUSH, FUNC_INSERT: begin
            if (c.func == FUNC_PUSH) slot = 0;
            // a full store wins over a bad position
            if (list_mirror.size() >= LIST_DEPTH) r.status = STATUS_FULL;
            else if (slot > list_mirror.size()) r.status = STATUS_RANGE;
            else list_mirror.insert(slot, c.value);
         end
         FUNC_DELETE, FUNC_GET: begin
            if (slot >= list_mirror.size()) begin
               r.status = STATUS_RANGE;
            end else begin
               r.data = list_mirror[slot];
               if (c.func == FUNC_DELETE) list_mirror.delete(slot);
            end
         end
         default: ;
      endcase
      r.length = LEN_W'(list_mirror.size());
      if (r.status == STATUS_FULL) full_seen++;
      if (r.status == STATUS_RANGE) range_seen++;
      if (list_mirror.size() > peak_length) peak_length = list_mirror.size();
      due_results.push_back(r);
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_cmd(input logic [FUNC_W-1:0] f, input int unsigned pos,
                            input logic [DATA_W-1:0] v, input int unsigned gap,
                            input bit drain);
      queued_cmd_type q;
      q.cmd.func     = f;
      q.cmd.position = POS_W'(pos);
      q.cmd.value    = v;
      q.gap          = gap;
      q.drain        = drain;
      // keep the queue short so positions follow the current list length
      while (pending_cmds.size() >= 2) @(posedge clock);
      pending_cmds.push_back(q);
   endtask

   // driver: offers the queued items, with a gap drawn for each one
   int unsigned send_gap;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_list_op(req_bus.payload);
            items_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               req_bus.valid <= 1'b0;
               send_gap      <= send_gap - 1;
            end else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain && due_results.size() > 0)) begin
               req_bus.valid   <= 1'b1;
               req_bus.payload <= pending_cmds[0].cmd;
               send_gap        <= pending_cmds[0].gap;
               void'(pending_cmds.pop_front());
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: takes results with random stalls and checks them in order
   int unsigned hold_left;
   ple_rsp_type got;
   ple_rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (due_results.size() == 0) begin
               $error("unexpected result: data %0d status %0d length %0d",
                      got.data, got.status, got.length);
               error_count++;
            end else begin
               want = due_results.pop_front();
               results_checked++;
               if (got.data !== want.data) begin
                  $error("data: expected %0d, actual %0d", want.data, got.data);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  error_count++;
               end
               if (got.length !== want.length) begin
                  $error("length: expected %0d, actual %0d", want.length, got.length);
                  error_count++;
               end
            end
            hold_left = rsp_eager ? 0 : $urandom_range(0, 12);
         end
         if (long_hold_done != long_hold_asked) begin
            long_hold_done = long_hold_asked;
            hold_left      = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("positional_list_engine regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      mix_kind_type mix;
      int unsigned phase;
      int unsigned roll;
      int unsigned pos;
      int unsigned n;
      int unsigned gap;
      bit          eager;
      logic [FUNC_W-1:0] f;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, ends of the list, position zero, value extremes
      queue_cmd(FUNC_GET,    1,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_DELETE, 0,  32'h0,         2, 1'b0);
      queue_cmd(FUNC_CLEAR,  0,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_INSERT, 2,  32'h1234_5678, 1, 1'b0);
      queue_cmd(FUNC_INSERT, 0,  32'h7fff_ffff, 0, 1'b0);
      queue_cmd(FUNC_PUSH,   0,  32'h8000_0000, 3, 1'b0);
      queue_cmd(FUNC_INSERT, 3,  32'hffff_ffff, 0, 1'b0);
      queue_cmd(FUNC_INSERT, 2,  32'h0000_0000, 0, 1'b0);
      queue_cmd(FUNC_GET,    0,  32'hffff_ffff, 5, 1'b0);
      queue_cmd(FUNC_GET,    4,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_GET,    5,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_GET,    64, 32'h0,         1, 1'b0);
      queue_cmd(FUNC_DELETE, 4,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_DELETE, 1,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_INSERT, 64, 32'h5a5a_5a5a, 2, 1'b0);
      queue_cmd(FUNC_DELETE, 0,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_DELETE, 9,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_CLEAR,  7,  32'hffff_ffff, 0, 1'b0);
      queue_cmd(FUNC_GET,    1,  32'h0,         0, 1'b0);
      queue_cmd(FUNC_PUSH,   0,  32'h5555_5555, 0, 1'b1);
      queue_cmd(FUNC_PUSH,   0,  32'haaaa_aaaa, 4, 1'b0);
      queue_cmd(FUNC_DELETE, 2,  32'h0,         0, 1'b0);

      // random: alternating growth and shrink phases with random content
      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         phase = i / PHASE_ITEMS;
         case (phase % 8)
            0, 1, 2: mix = MIX_GROW;
            4, 5, 6: mix = MIX_SHRINK;
            default: mix = MIX_EVEN;
         endcase
         eager     = (phase % 5 == 2);
         rsp_eager = eager;
         // stall the result side for a long stretch while items keep coming
         if (i % PHASE_ITEMS == 0 && (phase == 4 || phase == 17)) long_hold_asked++;

         roll = $urandom_range(0, 99);
         if (roll == 0) begin
            f = FUNC_CLEAR;
         end else if (roll == 1) begin
            // codes with no operation behind them
            f = FUNC_SPARE_LO + FUNC_W'($urandom_range(0, 2));
         end else begin
            case (mix)
               MIX_GROW:   f = (roll < 45) ? FUNC_PUSH : (roll < 80) ? FUNC_INSERT :
                               (roll < 90) ? FUNC_DELETE : FUNC_GET;
               MIX_SHRINK: f = (roll < 70) ? FUNC_DELETE : (roll < 85) ? FUNC_GET :
                               (roll < 93) ? FUNC_INSERT : FUNC_PUSH;
               default:    f = (roll < 25) ? FUNC_PUSH : (roll < 50) ? FUNC_INSERT :
                               (roll < 75) ? FUNC_DELETE : FUNC_GET;
            endcase
         end

         n = list_mirror.size();
         if ($urandom_range(0, 3) == 0) pos = $urandom_range(0, MAX_POS);
         else pos = $urandom_range(0, n + 1);
         if (pos > MAX_POS) pos = MAX_POS;

         gap = eager ? 0 : $urandom_range(0, 12);
         queue_cmd(f, pos, pick_value(), gap, (i % PHASE_ITEMS == PHASE_ITEMS / 2));
      end

      while (pending_cmds.size() != 0 || req_bus.valid || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         $error("%0d results never arrived", due_results.size());
         error_count++;
      end

      $display("sent %0d commands, checked %0d results, peak list length %0d",
               items_sent, results_checked, peak_length);
      $display("full-store rejects %0d, position or empty-list rejects %0d",
               full_seen, range_seen);
      if (error_count == 0) begin
         $display("positional_list_engine regression: pass");
      end else begin
         $display("positional_list_engine regression: fail");
      end
      $finish;
   end

endmodule
